// ----- rtl/pomut_pkg.sv -----
// Shared constants and types for the per-owner memory usage table.
package pomut_pkg;

    localparam int SLOTS_DEFAULT = 4096;
    localparam int TAG_W         = 32;
    localparam int USAGE_W       = 48;
    localparam int SIZE_W        = 32;
    localparam int COUNT_W       = 32;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [USAGE_W-1:0] usage;
    } slot_entry_t;

endpackage

// ----- rtl/pomut_table.sv -----
// Slot memory with post-reset clearing sweep and write-to-read bypass.
module pomut_table
    import pomut_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int IDX_W = $clog2(SLOTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  slot_entry_t      wr_data,
    output slot_entry_t      rd_data,
    output logic             clearing
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    slot_entry_t      mem [SLOTS];
    slot_entry_t      rd_data_reg;
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Bypass the write landing this edge so a back-to-back beat sees it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_idx];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// ----- rtl/per_owner_memory_usage_table.sv -----
// Per-owner memory usage table: top level with global counters and slot update.
//
// Usage:
//   Drive kind, owner and size_bytes with start high; the beat is taken at a
//   rising edge where start is high and busy is low. kind 0 adds size_bytes,
//   kind 1 subtracts it.
//   Each beat yields one result: done is high for exactly one cycle with
//   accounted, owner_usage, total_used and block_count valid in that cycle.
//   The receiver has no way to stall; results must be taken when done is up.
// Pipeline and throughput:
//   The accepting edge loads the s1 registers and the slot read register;
//   done is registered from s1. One beat per cycle is sustained once busy
//   is low, including back-to-back beats to the same slot: the slot memory
//   read is registered, and a write landing on the same edge as the read is
//   bypassed into the read register.
// Reset:
//   rst_n clears the global counters, then a sweep zeroes every slot entry,
//   one per cycle. busy stays high during the sweep.
module per_owner_memory_usage_table
    import pomut_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      kind,
    input  logic [TAG_W-1:0]          owner,
    input  logic [SIZE_W-1:0]         size_bytes,
    output logic                      done,
    output logic                      accounted,
    output logic signed [USAGE_W-1:0] owner_usage,
    output logic [USAGE_W-1:0]        total_used,
    output logic [COUNT_W-1:0]        block_count
);

    localparam int               IDX_W    = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(SLOTS - 1);

    logic             accept;
    logic             clearing;
    logic [IDX_W-1:0] rd_idx;
    slot_entry_t      rd_data;
    slot_entry_t      wr_data;

    logic               s1_valid_reg;
    logic               s1_kind_reg;
    logic [TAG_W-1:0]   s1_owner_reg;
    logic [SIZE_W-1:0]  s1_size_reg;
    logic [IDX_W-1:0]   s1_idx_reg;

    logic               done_reg;
    logic               accounted_reg;
    logic [USAGE_W-1:0] owner_usage_reg;
    logic [USAGE_W-1:0] used_total_reg;
    logic [COUNT_W-1:0] live_blocks_reg;

    logic               claim;
    logic               usage_neg;
    logic [TAG_W-1:0]   tag_next;
    logic [USAGE_W-1:0] base_usage;
    logic               hit;
    logic [USAGE_W-1:0] size_ext;
    logic [USAGE_W-1:0] usage_next;
    logic [USAGE_W-1:0] used_total_next;
    logic [COUNT_W-1:0] live_blocks_next;

    assign accept = start && !busy;
    assign busy   = clearing;
    assign rd_idx = owner[IDX_W-1:0] & IDX_MASK;

    pomut_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_idx   (rd_idx),
        .wr_en    (s1_valid_reg),
        .wr_idx   (s1_idx_reg),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind;
            s1_owner_reg <= owner;
            s1_size_reg  <= size_bytes;
            s1_idx_reg   <= rd_idx;
        end
    end

    // Claim a free or drained slot, charge it if the owner holds it, and step the global counters.
    always_comb
    begin
        size_ext   = USAGE_W'(s1_size_reg);
        usage_neg  = rd_data.usage[USAGE_W-1];
        claim      = (rd_data.tag == '0) || (rd_data.usage == '0) || usage_neg;
        tag_next   = claim ? s1_owner_reg : rd_data.tag;
        base_usage = (claim && usage_neg) ? '0 : rd_data.usage;
        hit        = (tag_next == s1_owner_reg);
        if (!hit)
        begin
            usage_next = base_usage;
        end
        else if (s1_kind_reg == KIND_FREE)
        begin
            usage_next = base_usage - size_ext;
        end
        else
        begin
            usage_next = base_usage + size_ext;
        end
        if (s1_kind_reg == KIND_FREE)
        begin
            used_total_next  = used_total_reg - size_ext;
            live_blocks_next = live_blocks_reg - 1'b1;
        end
        else
        begin
            used_total_next  = used_total_reg + size_ext;
            live_blocks_next = live_blocks_reg + 1'b1;
        end
        wr_data.tag   = tag_next;
        wr_data.usage = usage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            used_total_reg  <= '0;
            live_blocks_reg <= '0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                used_total_reg  <= used_total_next;
                live_blocks_reg <= live_blocks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            accounted_reg   <= hit;
            owner_usage_reg <= hit ? usage_next : '0;
        end
    end

    assign done        = done_reg;
    assign accounted   = accounted_reg;
    assign owner_usage = signed'(owner_usage_reg);
    assign total_used  = used_total_reg;
    assign block_count = live_blocks_reg;

`ifndef NO_ASSERTIONS
    a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted beat produced no result");

    a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted beat");

    a_unaccounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accounted) |-> (owner_usage == '0))
        else $error("unaccounted result carries nonzero usage");

    a_busy_only_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(busy))
        else $error("busy reasserted after the clearing sweep");
`endif

endmodule

// ----- bench/pomut_bench_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks per-owner usage table results.
package pomut_bench_pkg;

    import pomut_pkg::*;

    typedef struct {
        bit                 acc;
        bit [USAGE_W-1:0]   usage;
        bit [USAGE_W-1:0]   total;
        bit [COUNT_W-1:0]   blocks;
    } usage_result_t;

    class usage_scoreboard;

        bit [TAG_W-1:0]   slot_owner [SLOTS_DEFAULT];
        bit [USAGE_W-1:0] slot_bytes [SLOTS_DEFAULT];
        bit [USAGE_W-1:0] bytes_in_use;
        bit [COUNT_W-1:0] live_count;
        usage_result_t    expected_q [$];
        int               errors;

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        // Update global counters, claim the slot if it is free or not positive,
        // then charge the owner when it holds the slot.
        function void note_event(bit k, bit [TAG_W-1:0] o, bit [SIZE_W-1:0] sz);
            int unsigned      idx;
            bit [USAGE_W-1:0] u;
            bit               hit;
            usage_result_t    r;
            idx = o & (SLOTS_DEFAULT - 1);
            if (k == KIND_FREE)
            begin
                bytes_in_use = bytes_in_use - USAGE_W'(sz);
                live_count   = live_count - 1'b1;
            end
            else
            begin
                bytes_in_use = bytes_in_use + USAGE_W'(sz);
                live_count   = live_count + 1'b1;
            end
            u = slot_bytes[idx];
            if (slot_owner[idx] == '0 || u == '0 || u[USAGE_W-1])
            begin
                slot_owner[idx] = o;
                if (u[USAGE_W-1])
                    u = '0;
            end
            hit = (slot_owner[idx] == o);
            if (hit)
                u = (k == KIND_FREE) ? u - USAGE_W'(sz) : u + USAGE_W'(sz);
            slot_bytes[idx] = u;
            r.acc    = hit;
            r.usage  = hit ? u : '0;
            r.total  = bytes_in_use;
            r.blocks = live_count;
            expected_q.push_back(r);
        endfunction

        task check_result(logic acc, logic [USAGE_W-1:0] usage,
                          logic [USAGE_W-1:0] total, logic [COUNT_W-1:0] blocks);
            usage_result_t w;
            if (expected_q.size() == 0)
            begin
                report("result with nothing outstanding");
                return;
            end
            w = expected_q.pop_front();
            if (acc !== w.acc)
                report($sformatf("accounted got %0b want %0b", acc, w.acc));
            if (usage !== w.usage)
                report($sformatf("owner_usage got %h want %h", usage, w.usage));
            if (total !== w.total)
                report($sformatf("total_used got %h want %h", total, w.total));
            if (blocks !== w.blocks)
                report($sformatf("block_count got %h want %h", blocks, w.blocks));
        endtask

    endclass

endpackage

// ----- bench/tb_per_owner_memory_usage_table.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the per-owner memory usage table.
module tb_per_owner_memory_usage_table;

    import pomut_pkg::*;
    import pomut_bench_pkg::*;

    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_BEATS  = 120;
    localparam int HOT_SLOTS    = 8;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      kind = KIND_ALLOC;
    logic [TAG_W-1:0]          owner = '0;
    logic [SIZE_W-1:0]         size_bytes = '0;
    logic                      busy;
    logic                      done;
    logic                      accounted;
    logic signed [USAGE_W-1:0] owner_usage;
    logic [USAGE_W-1:0]        total_used;
    logic [COUNT_W-1:0]        block_count;

    usage_scoreboard ledger = new();
    int              idle_pct = 0;
    int              quiet_cycles = 0;
    int unsigned     hot_slot [HOT_SLOTS];
    bit [TAG_W-1:0]  upper_pool [4];

    per_owner_memory_usage_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .owner       (owner),
        .size_bytes  (size_bytes),
        .done        (done),
        .accounted   (accounted),
        .owner_usage (owner_usage),
        .total_used  (total_used),
        .block_count (block_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                ledger.check_result(accounted, owner_usage, total_used, block_count);
            if (start && !busy)
                ledger.note_event(kind, owner, size_bytes);
        end
    end

    // Count cycles with no beat taken and no result seen; fail the run at STALL_LIMIT.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(bit k, bit [TAG_W-1:0] o, bit [SIZE_W-1:0] sz);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        owner      <= o;
        size_bytes <= sz;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold the sender until every outstanding result is back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_beat();
        bit [TAG_W-1:0]  o;
        bit [SIZE_W-1:0] sz;
        bit              k;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 85)
            o = (upper_pool[$urandom_range(3)] & ~TAG_W'(SLOTS_DEFAULT - 1))
                | TAG_W'(hot_slot[$urandom_range(HOT_SLOTS - 1)]);
        else
            o = $urandom();
        pick = $urandom_range(99);
        if (pick < 60)
            sz = $urandom_range(4096, 1);
        else if (pick < 72)
            sz = '0;
        else if (pick < 90)
            sz = $urandom();
        else
            sz = '1;
        k = ($urandom_range(99) < 45) ? KIND_FREE : KIND_ALLOC;
        send_beat(k, o, sz);
    endtask

    initial
    begin
        hot_slot[0] = 0;
        hot_slot[1] = SLOTS_DEFAULT - 1;
        for (int i = 2; i < HOT_SLOTS; i++)
            hot_slot[i] = $urandom_range(SLOTS_DEFAULT - 1);
        upper_pool[0] = '0;
        upper_pool[1] = '1;
        upper_pool[2] = $urandom();
        upper_pool[3] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats, back to back.
        idle_pct = 0;
        send_beat(KIND_FREE,  32'h0000_0005, 32'd100);       // counters wrap below zero
        send_beat(KIND_ALLOC, 32'h0000_0005, 32'd50);        // negative usage reclaimed
        send_beat(KIND_ALLOC, 32'h0000_1005, 32'd7);         // slot held by other owner
        send_beat(KIND_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF); // owner zero
        send_beat(KIND_ALLOC, 32'h0000_1000, 32'd1);         // zero tag still claimable
        send_beat(KIND_FREE,  32'h0000_0005, 32'd50);
        send_beat(KIND_ALLOC, 32'h0000_1005, 32'd3);         // zero usage claimable
        send_beat(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_ALLOC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_ALLOC, 32'hFFFF_F123, 32'd0);
        send_beat(KIND_ALLOC, 32'h8000_0123, 32'd9);
        send_beat(KIND_FREE,  32'hFFFF_F123, 32'hFFFF_FFFF);
        send_beat(KIND_ALLOC, 32'h8000_0123, 32'h8000_0000);
        send_beat(KIND_FREE,  32'hAAAA_A555, 32'h5555_5555);
        send_beat(KIND_ALLOC, 32'h5555_5AAA, 32'hAAAA_AAAA);
        send_beat(KIND_FREE,  32'h0000_0000, 32'd0);
        send_beat(KIND_FREE,  32'h0000_0000, 32'hFFFF_FFFF);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 54;
                3:       idle_pct = 33;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_BEATS; n++)
                random_beat();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
